// ----- src/fcrc_pkg.sv -----
// Shared types, constants and the CRC byte step for the frame checker.
`timescale 1ns / 1ps
`default_nettype none

package fcrc_pkg;

    localparam logic [7:0]  PACKET_BYTES  = 8'd64;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    localparam logic [31:0] POLY_RESET    = 32'h04C1_1DB7;
    localparam logic [31:0] INIT_RESET    = 32'h0000_0000;
    localparam logic [7:0]  HDR0_RESET    = 8'hAD;
    localparam logic [7:0]  HDR1_RESET    = 8'hE9;
    localparam logic [7:0]  HDR2_RESET    = 8'h00;
    localparam logic [31:0] CRC_MSB       = 32'h8000_0000;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRC_POLY      = 3'd0,
        REG_CRC_INIT      = 3'd1,
        REG_HEADER_FIRST  = 3'd2,
        REG_HEADER_SECOND = 3'd3,
        REG_HEADER_THIRD  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_HEADER = 2'd2,
        ERR_CRC    = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [31:0] poly;
        logic [31:0] init;
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [7:0]  hdr2;
    } cfg_t;

    typedef struct packed {
        logic       frame_ok;
        err_code_t  error_code;
        logic [7:0] flags;
    } verdict_t;

    // One byte through the MSB-first CRC, eight shift steps unrolled.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [31:0] poly);
        logic [31:0] r;
        r = crc_in ^ {data, 24'd0};
        for (int k = 0; k < 8; k++) begin
            if ((r & CRC_MSB) != 32'd0)
                r = {r[30:0], 1'b0} ^ poly;
            else
                r = {r[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/fcrc_cfg.sv -----
// Configuration register file for the frame checker.
`timescale 1ns / 1ps
`default_nettype none

module fcrc_cfg
    import fcrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CRC_POLY:      cfg_next.poly = cfg_data;
                REG_CRC_INIT:      cfg_next.init = cfg_data;
                REG_HEADER_FIRST:  cfg_next.hdr0 = cfg_data[7:0];
                REG_HEADER_SECOND: cfg_next.hdr1 = cfg_data[7:0];
                REG_HEADER_THIRD:  cfg_next.hdr2 = cfg_data[7:0];
                default:           cfg_next = cfg_reg;  // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly <= POLY_RESET;
            cfg_reg.init <= INIT_RESET;
            cfg_reg.hdr0 <= HDR0_RESET;
            cfg_reg.hdr1 <= HDR1_RESET;
            cfg_reg.hdr2 <= HDR2_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- src/fcrc_frame.sv -----
// Per-frame state: running CRC, byte count, header check, flags capture, verdict.
`timescale 1ns / 1ps
`default_nettype none

module fcrc_frame
    import fcrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_xfer,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire cfg_t       cfg,
    output logic            res_load,
    output verdict_t        res
);

    logic [31:0] crc_reg,   crc_next;
    logic [7:0]  count_reg, count_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic [7:0]  flags_reg, flags_next;

    logic [31:0] crc_start;
    logic [31:0] crc_upd;
    logic [7:0]  count_upd;
    logic        mismatch;
    logic        hdr_upd;
    logic [7:0]  flags_upd;

    always_comb
    begin
        crc_start = (count_reg == 8'd0) ? cfg.init : crc_reg;
        crc_upd   = crc_byte(crc_start, data_byte, cfg.poly);
        count_upd = (count_reg != COUNT_MAX) ? count_reg + 8'd1 : count_reg;

        case (count_reg)
            8'd0:    mismatch = (data_byte != cfg.hdr0);
            8'd1:    mismatch = (data_byte != cfg.hdr1);
            8'd2:    mismatch = (data_byte != cfg.hdr2);
            default: mismatch = 1'b0;
        endcase
        hdr_upd   = hdr_bad_reg | mismatch;
        flags_upd = (count_reg == 8'd3) ? data_byte : flags_reg;

        // Check order: length, then header, then CRC residue.
        if (count_upd != PACKET_BYTES)
            res.error_code = ERR_LENGTH;
        else if (hdr_upd)
            res.error_code = ERR_HEADER;
        else if (crc_upd != 32'd0)
            res.error_code = ERR_CRC;
        else
            res.error_code = ERR_NONE;
        res.frame_ok = (res.error_code == ERR_NONE);
        res.flags    = flags_upd;
        res_load     = in_xfer && last_byte;

        crc_next     = crc_reg;
        count_next   = count_reg;
        hdr_bad_next = hdr_bad_reg;
        flags_next   = flags_reg;
        if (in_xfer)
        begin
            crc_next = crc_upd;
            if (last_byte)
            begin
                count_next   = 8'd0;
                hdr_bad_next = 1'b0;
                flags_next   = 8'd0;
            end
            else
            begin
                count_next   = count_upd;
                hdr_bad_next = hdr_upd;
                flags_next   = flags_upd;
            end
        end
    end

    // CRC value is ignored at count zero, so no reset.
    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= 8'd0;
            hdr_bad_reg <= 1'b0;
            flags_reg   <= 8'd0;
        end
        else
        begin
            count_reg   <= count_next;
            hdr_bad_reg <= hdr_bad_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/fcrc_out.sv -----
// Result register with valid/ready output and input backpressure.
`timescale 1ns / 1ps
`default_nettype none

module fcrc_out
    import fcrc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_load,
    input  wire verdict_t   res,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            frame_ok,
    output logic [1:0]      error_code,
    output logic [7:0]      flags_byte
);

    logic     valid_reg, valid_next;
    verdict_t res_reg,   res_next;

    // Slot frees in the same cycle the held result transfers out.
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (res_load)
        begin
            valid_next = 1'b1;
            res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid  = valid_reg;
    assign frame_ok   = res_reg.frame_ok;
    assign error_code = res_reg.error_code;
    assign flags_byte = res_reg.flags;

endmodule

`default_nettype wire

// ----- src/frame_crc_header_checker.sv -----
// A verdict is registered and is valid in the cycle after the byte marked last transfers.
// Throughput: one byte per cycle while in_ready is high; the running CRC (eight unrolled
//   shift steps per byte) and the count/header state update in the cycle a byte transfers.
// The single result register frees as its verdict transfers, so input stalls only
//   while a verdict waits and out_ready is low.
// Reset: config registers return to their defaults, byte count and flags clear.
`timescale 1ns / 1ps
`default_nettype none

module frame_crc_header_checker
    import fcrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // byte stream in
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    // verdict out
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       frame_ok,
    output logic [1:0]                 error_code,
    output logic [7:0]                 flags_byte
);

    cfg_t     cfg;
    verdict_t res;
    logic     res_load;
    logic     in_xfer;

    // A byte transfer advances the frame state.
    assign in_xfer = in_valid && in_ready;

    fcrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // CRC, length count, header compare and verdict logic.
    fcrc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_xfer   (in_xfer),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg       (cfg),
        .res_load  (res_load),
        .res       (res)
    );

    // Verdict holding register; decides when the next byte may transfer.
    fcrc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_load   (res_load),
        .res        (res),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_ok   (frame_ok),
        .error_code (error_code),
        .flags_byte (flags_byte)
    );

endmodule

`default_nettype wire

// ----- test/tb_frame_crc_header_checker.sv -----
// Self-checking testbench for frame_crc_header_checker: byte frames scored against a CRC/header model.
`timescale 1ns / 1ps

module tb_frame_crc_header_checker;
    import fcrc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PRINT_CAP    = 100;
    localparam int FRAME_LEN    = int'(PACKET_BYTES);
    localparam int HDR_BYTES    = 3;
    localparam int FLAGS_POS    = HDR_BYTES;
    localparam int OPEN_HEAD    = 10;
    localparam int PHASE_FRAMES = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;

    // One byte of the stream and one predicted verdict.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_byte_t;

    typedef struct packed {
        logic       ok;
        err_code_t  code;
        logic [7:0] flags;
    } verdict_exp_t;

    // DUT connections; every input is known from time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte = '0;
    logic                  last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  frame_ok;
    logic [1:0]            error_code;
    logic [7:0]            flags_byte;

    // Bytes waiting to be driven and verdicts waiting to come out.
    rx_byte_t     tx_bytes[$];
    verdict_exp_t expected_verdicts[$];

    // Model copy of the configuration registers.
    logic [31:0] mdl_poly = POLY_RESET;
    logic [31:0] mdl_init = INIT_RESET;
    logic [7:0]  mdl_hdr [HDR_BYTES];

    // Model copy of the running frame state.
    logic [31:0] run_crc;
    logic [7:0]  run_count;
    logic        hdr_fail;
    logic [7:0]  flags_seen;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int error_count     = 0;
    int cycle_count     = 0;
    int bytes_accepted  = 0;
    int bytes_queued    = 0;
    int frames_queued   = 0;
    int verdicts_seen   = 0;
    int open_rest       = 0;
    int code_hits [4]   = '{0, 0, 0, 0};

    frame_crc_header_checker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_ok   (frame_ok),
        .error_code (error_code),
        .flags_byte (flags_byte)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // MSB-first CRC, one data bit per step: feedback is the register MSB xor the data bit.
    function automatic logic [31:0] crc_step_byte(input logic [31:0] crc,
                                                  input logic [7:0]  d,
                                                  input logic [31:0] poly);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = crc[31] ^ d[i];
            crc = {crc[30:0], 1'b0} ^ (fb ? poly : 32'd0);
        end
        return crc;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic push_byte(input logic [7:0] d, input logic last);
        tx_bytes.push_back('{data: d, last: last});
        bytes_queued++;
    endtask

    // Register write; the model follows at once since no transfer is in flight.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CRC_POLY:      mdl_poly   = val;
            REG_CRC_INIT:      mdl_init   = val;
            REG_HEADER_FIRST:  mdl_hdr[0] = val[7:0];
            REG_HEADER_SECOND: mdl_hdr[1] = val[7:0];
            REG_HEADER_THIRD:  mdl_hdr[2] = val[7:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Builds one frame under the current config.
    //   scramble : every byte random, no CRC tail
    //   hdr_hit  : header byte corrupted before the CRC is computed (CRC stays good)
    //   late_hit : one bit flipped after the CRC is computed
    task automatic queue_frame(input int len, input bit scramble,
                               input int hdr_hit, input int late_hit);
        logic [7:0]  fb [];
        logic [31:0] crc;
        fb = new[len];
        for (int i = 0; i < len; i++)
            fb[i] = (i < HDR_BYTES && !scramble) ? mdl_hdr[i] : 8'($urandom);
        if (hdr_hit >= 0 && hdr_hit < len)
            fb[hdr_hit] ^= 8'($urandom_range(1, 255));
        // CRC appended big-endian gives a zero residue for any polynomial
        if (!scramble && len >= 8)
        begin
            crc = mdl_init;
            for (int i = 0; i < len - 4; i++)
                crc = crc_step_byte(crc, fb[i], mdl_poly);
            for (int k = 0; k < 4; k++)
                fb[len - 4 + k] = crc[31 - 8 * k -: 8];
        end
        if (late_hit >= 0 && late_hit < len)
            fb[late_hit] ^= 8'(1 << $urandom_range(0, 7));
        for (int i = 0; i < len; i++)
            push_byte(fb[i], i == len - 1);
        frames_queued++;
    endtask

    // Idle means: nothing left to drive, nothing on the bus, no verdict owed,
    // plus a DRAIN_CYCLES wait in case the block is still busy on a non-final byte.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tx_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One phase: optional config, idle mix, a mostly well-formed random frame mix.
    // A phase may leave a frame open; the next one finishes it under the new config,
    // which exercises mid-frame register writes.
    task automatic run_phase(input bit write_cfg, input logic [31:0] poly,
                             input logic [31:0] init, input logic [7:0] h0,
                             input logic [7:0] h1, input logic [7:0] h2,
                             input int s_idle, input int r_stall,
                             input int long_len, input bit leave_open);
        int start_frames;
        int r;
        int len;
        wait_drained();
        if (write_cfg)
        begin
            cfg_write(REG_CRC_POLY, poly);
            cfg_write(REG_CRC_INIT, init);
            cfg_write(REG_HEADER_FIRST, {24'd0, h0});
            cfg_write(REG_HEADER_SECOND, {24'd0, h1});
            cfg_write(REG_HEADER_THIRD, {24'd0, h2});
            cfg_close();
        end
        @(negedge clk);
        sender_idle_pct = s_idle;
        recv_stall_pct  = r_stall;
        start_frames    = frames_queued;

        if (open_rest > 0)
        begin
            for (int i = 0; i < open_rest; i++)
                push_byte(8'($urandom), i == open_rest - 1);
            frames_queued++;
            open_rest = 0;
        end

        queue_frame(FRAME_LEN, 1'b0, -1, -1);
        if (long_len > 0)
            queue_frame(long_len, 1'b0, -1, -1);

        while (frames_queued - start_frames < PHASE_FRAMES)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                queue_frame(FRAME_LEN, 1'b0, -1, -1);
            else if (r < 55)
                queue_frame(FRAME_LEN, 1'b0, $urandom_range(0, HDR_BYTES - 1), -1);
            else if (r < 62)
                // header error that also breaks the CRC: header must win
                queue_frame(FRAME_LEN, 1'b0, -1, $urandom_range(0, HDR_BYTES - 1));
            else if (r < 74)
                queue_frame(FRAME_LEN, 1'b0, -1, $urandom_range(FLAGS_POS, FRAME_LEN - 1));
            else if (r < 88)
            begin
                // good content, wrong length; short ones biased small
                if ($urandom_range(0, 2) != 0)
                    len = $urandom_range(1, $urandom_range(4, FRAME_LEN - 1));
                else
                    len = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 24);
                queue_frame(len, 1'b0, -1, -1);
            end
            else
                queue_frame($urandom_range(1, FRAME_LEN + 8), 1'b1, -1, -1);
        end

        if (leave_open)
        begin
            for (int i = 0; i < OPEN_HEAD; i++)
                push_byte((i < HDR_BYTES) ? mdl_hdr[i] : 8'($urandom), 1'b0);
            open_rest = FRAME_LEN - OPEN_HEAD;
        end
    endtask

    // Driver: holds a byte until its transfer, predicts the verdict on each last-byte transfer.
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        logic [31:0]  seed;
        verdict_exp_t v;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= '0;
            last_byte  <= 1'b0;
            run_crc    = INIT_RESET;
            run_count  = '0;
            hdr_fail   = 1'b0;
            flags_seen = '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                bytes_accepted++;
                // count zero means start of frame: CRC seeds from the live init register
                seed    = (run_count == 8'd0) ? mdl_init : run_crc;
                run_crc = crc_step_byte(seed, data_byte, mdl_poly);
                if (run_count < HDR_BYTES && data_byte != mdl_hdr[run_count])
                    hdr_fail = 1'b1;
                if (run_count == FLAGS_POS)
                    flags_seen = data_byte;
                // count sticks at its max, so very long frames all look the same length
                if (run_count != COUNT_MAX)
                    run_count++;
                if (last_byte)
                begin
                    // priority: length, then header, then CRC residue
                    if (run_count != PACKET_BYTES)
                        v.code = ERR_LENGTH;
                    else if (hdr_fail)
                        v.code = ERR_HEADER;
                    else if (run_crc != 32'd0)
                        v.code = ERR_CRC;
                    else
                        v.code = ERR_NONE;
                    v.ok    = (v.code == ERR_NONE);
                    v.flags = flags_seen;
                    expected_verdicts.push_back(v);
                    run_count  = '0;
                    hdr_fail   = 1'b0;
                    flags_seen = '0;
                end
            end
            // load a new byte only when the bus is free or the current one just moved
            if (!in_valid || in_ready)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    data_byte <= tx_bytes[0].data;
                    last_byte <= tx_bytes[0].last;
                    tx_bytes.delete(0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: scores each verdict transfer against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : score_verdicts
        verdict_exp_t v;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch($sformatf("unexpected verdict ok=%0b code=%0d flags=%02h",
                                              frame_ok, error_code, flags_byte));
                else
                begin
                    v = expected_verdicts.pop_front();
                    verdicts_seen++;
                    code_hits[v.code]++;
                    if (frame_ok !== v.ok)
                        report_mismatch($sformatf("verdict %0d frame_ok %b, want %b",
                                                  verdicts_seen, frame_ok, v.ok));
                    if (error_code !== v.code)
                        report_mismatch($sformatf("verdict %0d error_code %0d, want %s",
                                                  verdicts_seen, error_code, v.code.name()));
                    if (flags_byte !== v.flags)
                        report_mismatch($sformatf("verdict %0d flags_byte %02h, want %02h",
                                                  verdicts_seen, flags_byte, v.flags));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles: %0d bytes unsent, %0d verdicts owed",
                     cycle_count, tx_bytes.size(), expected_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        mdl_hdr[0] = HDR0_RESET;
        mdl_hdr[1] = HDR1_RESET;
        mdl_hdr[2] = HDR2_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // writes to unmapped indexes must leave every register alone
        for (int i = REG_UNMAPPED_FIRST; i < (1 << CFG_IDX_W); i++)
            cfg_write(CFG_IDX_W'(i), '1);
        cfg_close();
        @(negedge clk);

        // Directed: short frames under reset config, data extremes, flags capture
        push_byte(8'h00, 1'b1);                         // one byte, flags stay zero
        push_byte(8'hFF, 1'b1);
        push_byte(HDR0_RESET, 1'b0);                    // header only, no flags byte
        push_byte(HDR1_RESET, 1'b0);
        push_byte(HDR2_RESET, 1'b1);
        push_byte(8'hFF, 1'b0);                         // four bytes: flags = last byte
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        push_byte(HDR0_RESET, 1'b0);
        push_byte(HDR1_RESET, 1'b0);
        push_byte(HDR2_RESET, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h01, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(8'hC3, 1'b1);
        frames_queued += 6;

        // Random phases: reset config, all-ones, all-zeros, random values
        run_phase(1'b0, POLY_RESET, INIT_RESET, HDR0_RESET, HDR1_RESET, HDR2_RESET,
                  0, 0, int'(COUNT_MAX), 1'b1);
        run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h80,
                  53, 0, 0, 1'b1);
        run_phase(1'b1, 32'h0000_0000, 32'h0000_0000, 8'hFF, 8'h00, 8'hFF,
                  0, 53, int'(COUNT_MAX) + 5, 1'b1);
        run_phase(1'b1, $urandom, $urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                  7, 7, 0, 1'b0);

        wait_drained();
        $display("Covered %0d bytes in %0d frames over four register settings plus short frames.",
                 bytes_accepted, frames_queued);
        $display("Verdicts checked: %0d (ok %0d, length %0d, header %0d, crc %0d).",
                 verdicts_seen, code_hits[ERR_NONE], code_hits[ERR_LENGTH],
                 code_hits[ERR_HEADER], code_hits[ERR_CRC]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
src/fcrc_pkg.sv
src/fcrc_cfg.sv
src/fcrc_frame.sv
src/fcrc_out.sv
src/frame_crc_header_checker.sv
test/tb_frame_crc_header_checker.sv
